// ===== rtl/core/sepwm_pkg.sv =====
package sepwm_pkg;

   localparam int MAX_CHANNELS = 6;
   localparam int DATA_BITS = 32;
   localparam int OP_BITS = 2;
   localparam int INDEX_BITS = 4;

   localparam int DEFAULT_NUM_CHANNELS = 6;
   localparam int DEFAULT_COUNT_BITS = 32;

   localparam logic [OP_BITS-1:0] OP_TICK = 2'd0;
   localparam logic [OP_BITS-1:0] OP_WRITE = 2'd1;
   localparam logic [OP_BITS-1:0] OP_READ = 2'd2;

   localparam logic [INDEX_BITS-1:0] REG_PERIOD = 4'd0;
   localparam logic [INDEX_BITS-1:0] REG_LATCH = 4'd7;
   localparam logic [INDEX_BITS-1:0] REG_ENABLE = 4'd8;
   localparam logic [INDEX_BITS-1:0] REG_CONTROL = 4'd9;

   localparam int CTRL_COUNT_BIT = 0;
   localparam int CTRL_PWM_BIT = 1;
   localparam int CTRL_BITS = 2;

   typedef struct packed {
      logic [OP_BITS-1:0] operation;
      logic [INDEX_BITS-1:0] reg_index;
      logic [DATA_BITS-1:0] write_data;
   } req_word_type;

   typedef struct packed {
      logic [MAX_CHANNELS-1:0] pwm_out;
      logic [DATA_BITS-1:0] read_data;
      logic cycle_start;
   } rsp_word_type;

endpackage

// ===== rtl/core/sepwm_if.sv =====
interface sepwm_req_if;
   logic valid;
   logic ready;
   logic [sepwm_pkg::OP_BITS-1:0] operation;
   logic [sepwm_pkg::INDEX_BITS-1:0] reg_index;
   logic [sepwm_pkg::DATA_BITS-1:0] write_data;

   modport source (output valid, output operation, output reg_index, output write_data,
                   input ready);
   modport sink (input valid, input operation, input reg_index, input write_data,
                 output ready);
endinterface

interface sepwm_rsp_if;
   logic valid;
   logic ready;
   logic [sepwm_pkg::MAX_CHANNELS-1:0] pwm_out;
   logic [sepwm_pkg::DATA_BITS-1:0] read_data;
   logic cycle_start;

   modport source (output valid, output pwm_out, output read_data, output cycle_start,
                   input ready);
   modport sink (input valid, input pwm_out, input read_data, input cycle_start,
                 output ready);
endinterface

// ===== rtl/core/single_edge_pwm_timer_unit.sv =====
// A word accepted into the input register is applied to the timer state, and its result is
// captured in the result register, from which it can then be taken.
// Throughput: one word per cycle while the response side is ready, set by the single update
// of the timer state between the input register and the result register.
// Reset (synchronous, active high) clears the counter, all match registers, the latch,
// the enable mask and the control register, and empties both pipeline registers.
module single_edge_pwm_timer_unit #(
   parameter int NUM_CHANNELS = sepwm_pkg::DEFAULT_NUM_CHANNELS,
   parameter int COUNT_BITS = sepwm_pkg::DEFAULT_COUNT_BITS
) (
   input  logic        clock,
   input  logic        reset,
   sepwm_req_if.sink   req_ch,
   sepwm_rsp_if.source rsp_ch
);
   import sepwm_pkg::*;

   logic in_valid_ff, in_valid_in;
   req_word_type in_word_ff, in_word_in;
   logic out_valid_ff, out_valid_in;
   rsp_word_type out_word_ff, out_word_in;

   logic advance;
   logic req_take;
   logic exec;
   rsp_word_type result;

   // The result register frees up whenever it is empty or being drained.
   assign advance = !out_valid_ff || rsp_ch.ready;
   assign req_ch.ready = !in_valid_ff || advance;
   assign req_take = req_ch.valid && req_ch.ready;
   assign exec = in_valid_ff && advance;

   always_comb begin
      in_word_in = in_word_ff;
      if (req_take) begin
         in_word_in.operation = req_ch.operation;
         in_word_in.reg_index = req_ch.reg_index;
         in_word_in.write_data = req_ch.write_data;
      end
      in_valid_in = req_take ? 1'b1 : (advance ? 1'b0 : in_valid_ff);
      out_word_in = exec ? result : out_word_ff;
      out_valid_in = exec ? 1'b1 : (rsp_ch.ready ? 1'b0 : out_valid_ff);
   end

   sepwm_engine #(
      .NUM_CHANNELS(NUM_CHANNELS),
      .COUNT_BITS(COUNT_BITS)
   ) u_engine (
      .clock(clock),
      .reset(reset),
      .exec(exec),
      .word(in_word_ff),
      .result(result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      in_word_ff <= in_word_in;
      out_word_ff <= out_word_in;
   end

   assign rsp_ch.valid = out_valid_ff;
   assign rsp_ch.pwm_out = out_word_ff.pwm_out;
   assign rsp_ch.read_data = out_word_ff.read_data;
   assign rsp_ch.cycle_start = out_word_ff.cycle_start;

endmodule

// ===== rtl/core/sepwm_engine.sv =====
module sepwm_engine #(
   parameter int NUM_CHANNELS = sepwm_pkg::DEFAULT_NUM_CHANNELS,
   parameter int COUNT_BITS = sepwm_pkg::DEFAULT_COUNT_BITS
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    exec,
   input  sepwm_pkg::req_word_type word,
   output sepwm_pkg::rsp_word_type result
);
   import sepwm_pkg::*;

   localparam int NUM_MATCH = NUM_CHANNELS + 1;
   localparam int MATCH_IDX_BITS = $clog2(NUM_MATCH);

   logic [COUNT_BITS-1:0] counter_ff, counter_in;
   logic [COUNT_BITS-1:0] shadow_ff [NUM_MATCH];
   logic [COUNT_BITS-1:0] shadow_in [NUM_MATCH];
   logic [COUNT_BITS-1:0] active_ff [NUM_MATCH];
   logic [COUNT_BITS-1:0] active_in [NUM_MATCH];
   logic [NUM_CHANNELS:0] latch_ff, latch_in;
   logic [NUM_CHANNELS-1:0] enable_ff, enable_in;
   logic [CTRL_BITS-1:0] control_ff, control_in;

   logic match_sel;
   logic [MATCH_IDX_BITS-1:0] match_idx;
   logic [DATA_BITS-1:0] read_value;
   logic wrap;
   logic [NUM_CHANNELS-1:0] levels;

   assign match_sel = word.reg_index <= INDEX_BITS'(NUM_CHANNELS);
   assign match_idx = word.reg_index[MATCH_IDX_BITS-1:0];

   always_comb begin
      counter_in = counter_ff;
      shadow_in = shadow_ff;
      active_in = active_ff;
      latch_in = latch_ff;
      enable_in = enable_ff;
      control_in = control_ff;
      read_value = '0;
      wrap = 1'b0;
      if (exec) begin
         unique case (word.operation)
            OP_TICK: begin
               if (control_ff[CTRL_COUNT_BIT]) begin
                  if (counter_ff == active_ff[0]) begin
                     // Restart the period and load every pending shadow match.
                     counter_in = '0;
                     wrap = 1'b1;
                     for (int i = 0; i < NUM_MATCH; i++) begin
                        if (latch_ff[i]) begin
                           active_in[i] = shadow_ff[i];
                        end
                     end
                     latch_in = '0;
                  end else begin
                     counter_in = counter_ff + COUNT_BITS'(1);
                  end
               end
            end
            OP_WRITE: begin
               priority if (match_sel) begin
                  shadow_in[match_idx] = word.write_data[COUNT_BITS-1:0];
               end else if (word.reg_index == REG_LATCH) begin
                  latch_in = latch_ff | word.write_data[NUM_CHANNELS:0];
               end else if (word.reg_index == REG_ENABLE) begin
                  enable_in = word.write_data[NUM_CHANNELS-1:0];
               end else if (word.reg_index == REG_CONTROL) begin
                  control_in = word.write_data[CTRL_BITS-1:0];
               end else begin
                  // Writes to unused indexes are dropped.
                  control_in = control_ff;
               end
            end
            OP_READ: begin
               priority if (match_sel) begin
                  read_value = DATA_BITS'(shadow_ff[match_idx]);
               end else if (word.reg_index == REG_LATCH) begin
                  read_value = DATA_BITS'(latch_ff);
               end else if (word.reg_index == REG_ENABLE) begin
                  read_value = DATA_BITS'(enable_ff);
               end else if (word.reg_index == REG_CONTROL) begin
                  read_value = DATA_BITS'(control_ff);
               end else begin
                  read_value = '0;
               end
            end
            default: begin
            end
         endcase
      end
   end

   // Channel levels reflect the state after this word has been applied.
   always_comb begin
      for (int ch = 0; ch < NUM_CHANNELS; ch++) begin
         levels[ch] = control_in[CTRL_COUNT_BIT] && control_in[CTRL_PWM_BIT] &&
                      enable_in[ch] && (counter_in < active_in[ch + 1]);
      end
   end

   assign result.pwm_out = MAX_CHANNELS'(levels);
   assign result.read_data = read_value;
   assign result.cycle_start = wrap;

   always_ff @(posedge clock) begin
      if (reset) begin
         counter_ff <= '0;
         latch_ff <= '0;
         enable_ff <= '0;
         control_ff <= '0;
         for (int i = 0; i < NUM_MATCH; i++) begin
            shadow_ff[i] <= '0;
            active_ff[i] <= '0;
         end
      end else begin
         counter_ff <= counter_in;
         latch_ff <= latch_in;
         enable_ff <= enable_in;
         control_ff <= control_in;
         shadow_ff <= shadow_in;
         active_ff <= active_in;
      end
   end

endmodule
